[sv/cget_pkg.sv]
package cget_pkg;

    localparam int MAX_LOOKAHEAD = 16;
    localparam int SLOT_W = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int WIN_W = $clog2(MAX_LOOKAHEAD + 1);

    localparam int LA_W = 5;
    localparam int STEPS_W = 16;
    localparam int HALF_W = 32;
    localparam int WORD_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOK_AHEAD = 3'd0,
        CFG_MAX_STEPS  = 3'd1,
        CFG_REL_TOL    = 3'd2,
        CFG_ABS_TOL    = 3'd3,
        CFG_EPS        = 3'd4,
        CFG_MIN_ACC    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_MUL,
        ST_UPDATE,
        ST_WIN_RD,
        ST_WIN_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_REL,
        SEL_EPS,
        SEL_MIN
    } tol_sel_t;

    typedef struct packed {
        logic idle;
        logic accept;
        logic clear;
        logic mul_term;
        logic update;
        logic win_rd;
        logic win_acc;
        logic mul_lo;
        logic mul_hi;
        logic eval;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic item_clear;
        logic win_none;
        logic tol_last;
        logic out_free;
    } stat_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

    function automatic logic [WIN_W-1:0] eff_depth(input logic [LA_W-1:0] la);
        if (int'(la) > MAX_LOOKAHEAD)
        begin
            return WIN_W'(MAX_LOOKAHEAD);
        end
        return WIN_W'(la);
    endfunction

endpackage

[sv/cget_if.sv]
interface cget_in_if import cget_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [HALF_W-1:0]        alpha;
    logic [HALF_W-1:0]        r_pinv_r;
    logic signed [WORD_W-1:0] q_a_q;

    modport source (output valid, output op, output alpha, output r_pinv_r,
                    output q_a_q, input ready);
    modport sink (input valid, input op, input alpha, input r_pinv_r,
                  input q_a_q, output ready);
endinterface

interface cget_out_if import cget_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               terminate;
    logic               vanishing_step;
    logic               minimal_decrease;
    logic [STEPS_W-1:0] step_count;

    modport source (output valid, output terminate, output vanishing_step,
                    output minimal_decrease, output step_count, input ready);
    modport sink (input valid, input terminate, input vanishing_step,
                  input minimal_decrease, input step_count, output ready);
endinterface

interface cget_cfg_if import cget_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/cget_mul.sv]
module cget_mul import cget_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [HALF_W-1:0] a,
    input  logic [HALF_W-1:0] b,
    output logic [WORD_W-1:0] prod
);

    logic [WORD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= WORD_W'(a) * WORD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

[sv/cget_ring.sv]
module cget_ring import cget_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [SLOT_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [MAX_LOOKAHEAD];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/cget_seq.sv]
module cget_seq import cget_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.item_valid)
                begin
                    state_next = stat.item_clear ? ST_MUL_LO : ST_TERM_MUL;
                end
            end
            ST_TERM_MUL: state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_WIN_RD;
            ST_WIN_RD:   state_next = stat.win_none ? ST_MUL_LO : ST_WIN_ACC;
            ST_WIN_ACC:  state_next = ST_WIN_RD;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_EVAL;
            ST_EVAL:     state_next = stat.tol_last ? ST_DONE : ST_MUL_LO;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.idle   = 1'b1;
                ctrl.accept = stat.item_valid;
                ctrl.clear  = stat.item_valid && stat.item_clear;
            end
            ST_TERM_MUL: ctrl.mul_term = 1'b1;
            ST_UPDATE:   ctrl.update = 1'b1;
            ST_WIN_RD:   ctrl.win_rd = !stat.win_none;
            ST_WIN_ACC:  ctrl.win_acc = 1'b1;
            ST_MUL_LO:   ctrl.mul_lo = 1'b1;
            ST_MUL_HI:   ctrl.mul_hi = 1'b1;
            ST_EVAL:     ctrl.eval = 1'b1;
            ST_DONE:     ctrl.load_out = stat.out_free;
            default:     ctrl = '0;
        endcase
    end

endmodule

[sv/cg_energy_error_termination_top.sv]
// Energy-error termination test for a preconditioned CG solver. Each update
// request carries alpha and r'P^-1 r (Q16.16) and q'Aq (Q32.32); a clear
// request zeroes the history, energy and step count but keeps |q'Aq|. Every
// request returns one result with terminate, vanishing_step,
// minimal_decrease and the step count. All products go through one 32x32
// multiplier and the last look_ahead terms sit in a small ring memory with a
// registered read. An update forms the new term, writes it to the ring, reads
// and adds n window terms, where n = min(step count, look_ahead, 16), then
// makes three multiplier passes, one per tolerance; a clear makes only the
// three passes. The block takes one request at a time; a finished result
// waits in an output register while the next request is worked on.
module cg_energy_error_termination_top import cget_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cget_in_if.sink     item,
    cget_out_if.source  result,
    cget_cfg_if.sink    cfg
);

    ctrl_t ctrl;
    stat_t stat;

    // configuration
    logic [LA_W-1:0]    look_ahead_reg;
    logic [STEPS_W-1:0] max_steps_reg;
    logic [HALF_W-1:0]  rel_tol_reg;
    logic [WORD_W-1:0]  abs_tol_reg;
    logic [HALF_W-1:0]  eps_reg;
    logic [HALF_W-1:0]  min_acc_reg;

    // accumulated state
    logic [SLOT_W-1:0]  write_slot_reg;
    logic [WORD_W-1:0]  window_reg;
    logic [WORD_W-1:0]  energy_reg;
    logic [WORD_W-1:0]  step_length_reg;
    logic [STEPS_W-1:0] count_reg;

    // sequencing
    logic [WIN_W-1:0]   win_left_reg;
    logic [SLOT_W-1:0]  rd_ptr_reg;
    tol_sel_t           tol_sel_reg;

    // payload
    logic [HALF_W-1:0]  alpha_reg;
    logic [HALF_W-1:0]  rpr_reg;
    logic [WORD_W-1:0]  lo_part_reg;
    logic               rel_hit_reg;
    logic               van_hit_reg;
    logic               min_hit_reg;

    logic               out_valid_reg;
    logic               terminate_reg;
    logic               vanishing_reg;
    logic               min_dec_reg;
    logic [STEPS_W-1:0] step_count_reg;

    logic [WIN_W-1:0]   d_eff;
    logic [STEPS_W-1:0] d_cnt;
    logic [STEPS_W-1:0] count_inc;
    logic [SLOT_W-1:0]  slot_inc;
    logic [SLOT_W-1:0]  ptr_dec;
    logic [WORD_W-1:0]  q_bits;
    logic [HALF_W-1:0]  tol_cur;
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [WORD_W-1:0]  prod;
    logic [WORD_W-1:0]  ring_rdata;
    logic [WORD_W-1:0]  hi_sum;
    logic               below;
    logic [WORD_W-1:0]  tol_van;

    cget_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    cget_mul u_mul
    (
        .clk  (clk),
        .en   (ctrl.mul_term || ctrl.mul_lo || ctrl.mul_hi),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    cget_ring u_ring
    (
        .clk   (clk),
        .we    (ctrl.update),
        .waddr (write_slot_reg),
        .wdata (prod),
        .re    (ctrl.win_rd),
        .raddr (rd_ptr_reg),
        .rdata (ring_rdata)
    );

    assign item.ready = ctrl.idle;
    assign cfg.ready  = 1'b1;

    assign stat.item_valid = item.valid;
    assign stat.item_clear = (item.op == OP_CLEAR);
    assign stat.win_none   = (win_left_reg == '0);
    assign stat.tol_last   = (tol_sel_reg == SEL_MIN);
    assign stat.out_free   = !out_valid_reg || result.ready;

    assign d_eff     = eff_depth(look_ahead_reg);
    assign d_cnt     = STEPS_W'(d_eff);
    assign count_inc = (count_reg == {STEPS_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign slot_inc  = (write_slot_reg == SLOT_W'(MAX_LOOKAHEAD - 1)) ? '0
                                                                      : write_slot_reg + 1'b1;
    assign ptr_dec   = (rd_ptr_reg == '0) ? SLOT_W'(MAX_LOOKAHEAD - 1) : rd_ptr_reg - 1'b1;
    assign q_bits    = item.q_a_q;

    always_comb
    begin
        case (tol_sel_reg)
            SEL_REL: tol_cur = rel_tol_reg;
            SEL_EPS: tol_cur = eps_reg;
            SEL_MIN: tol_cur = min_acc_reg;
            default: tol_cur = '0;
        endcase
    end

    assign mul_a = ctrl.mul_term ? alpha_reg : tol_cur;
    assign mul_b = ctrl.mul_term ? rpr_reg
                 : (ctrl.mul_hi ? energy_reg[WORD_W-1:HALF_W] : energy_reg[HALF_W-1:0]);

    // tol * energy = hi * 2^32 + lo; hi is the high partial plus the carry-in of the low one
    assign hi_sum  = prod + {{HALF_W{1'b0}}, lo_part_reg[WORD_W-1:HALF_W]};
    assign below   = (window_reg != hi_sum) ? (window_reg < hi_sum)
                                            : (lo_part_reg[HALF_W-1:0] != '0);
    assign tol_van = ((energy_reg > abs_tol_reg) && (hi_sum < abs_tol_reg)) ? hi_sum
                                                                          : abs_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_ahead_reg <= LA_W'(1);
            max_steps_reg  <= STEPS_W'(1000);
            rel_tol_reg    <= '0;
            abs_tol_reg    <= '0;
            eps_reg        <= '0;
            min_acc_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_LOOK_AHEAD: look_ahead_reg <= cfg.data[LA_W-1:0];
                CFG_MAX_STEPS:  max_steps_reg  <= cfg.data[STEPS_W-1:0];
                CFG_REL_TOL:    rel_tol_reg    <= cfg.data[HALF_W-1:0];
                CFG_ABS_TOL:    abs_tol_reg    <= cfg.data;
                CFG_EPS:        eps_reg        <= cfg.data[HALF_W-1:0];
                CFG_MIN_ACC:    min_acc_reg    <= cfg.data[HALF_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            window_reg      <= '0;
            energy_reg      <= '0;
            step_length_reg <= '0;
            count_reg       <= '0;
            win_left_reg    <= '0;
            rd_ptr_reg      <= '0;
            tol_sel_reg     <= SEL_REL;
        end
        else
        begin
            if (ctrl.accept)
            begin
                tol_sel_reg <= SEL_REL;
            end
            if (ctrl.clear)
            begin
                write_slot_reg <= '0;
                window_reg     <= '0;
                energy_reg     <= '0;
                count_reg      <= '0;
                win_left_reg   <= '0;
            end
            else if (ctrl.accept)
            begin
                step_length_reg <= q_bits[WORD_W-1] ? (~q_bits + 1'b1) : q_bits;
            end
            if (ctrl.update)
            begin
                energy_reg     <= sat_add(energy_reg, prod);
                count_reg      <= count_inc;
                write_slot_reg <= slot_inc;
                window_reg     <= '0;
                rd_ptr_reg     <= write_slot_reg;
                win_left_reg   <= (count_inc < d_cnt) ? WIN_W'(count_inc) : d_eff;
            end
            if (ctrl.win_rd)
            begin
                rd_ptr_reg   <= ptr_dec;
                win_left_reg <= win_left_reg - 1'b1;
            end
            if (ctrl.win_acc)
            begin
                window_reg <= sat_add(window_reg, ring_rdata);
            end
            if (ctrl.eval)
            begin
                case (tol_sel_reg)
                    SEL_REL: tol_sel_reg <= SEL_EPS;
                    SEL_EPS: tol_sel_reg <= SEL_MIN;
                    default: tol_sel_reg <= SEL_MIN;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            alpha_reg <= item.alpha;
            rpr_reg   <= item.r_pinv_r;
        end
        if (ctrl.mul_hi)
        begin
            lo_part_reg <= prod;
        end
        if (ctrl.eval)
        begin
            case (tol_sel_reg)
                SEL_REL: rel_hit_reg <= below;
                SEL_EPS: van_hit_reg <= (step_length_reg < tol_van);
                SEL_MIN: min_hit_reg <= below;
                default: ;
            endcase
        end
        if (ctrl.load_out)
        begin
            terminate_reg  <= (count_reg > max_steps_reg) || ((count_reg > d_cnt) && rel_hit_reg);
            vanishing_reg  <= van_hit_reg;
            min_dec_reg    <= (count_reg >= d_cnt) && min_hit_reg;
            step_count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.terminate        = terminate_reg;
    assign result.vanishing_step   = vanishing_reg;
    assign result.minimal_decrease = min_dec_reg;
    assign result.step_count       = step_count_reg;

endmodule

[sv/cget_checker.sv]
module cget_checker import cget_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_terminate,
    input logic               res_vanishing,
    input logic               res_min_dec,
    input logic [STEPS_W-1:0] res_count
);

    // a stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_count)
            && $stable(res_terminate) && $stable(res_vanishing) && $stable(res_min_dec))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request accepted while busy");

    // zero count means empty history and zero energy
    a_zero_term: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_count == '0) |-> !res_terminate)
        else $error("terminate with zero step count");

    a_zero_min: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_count == '0) |-> !res_min_dec)
        else $error("minimal decrease with zero step count");

endmodule

bind cg_energy_error_termination_top cget_checker u_cget_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_terminate (result.terminate),
    .res_vanishing (result.vanishing_step),
    .res_min_dec   (result.minimal_decrease),
    .res_count     (result.step_count)
);
